/* rtl/cbpo_pkg.sv */
// constants, types and helper functions for the corner badge pixel overlay
package cbpo_pkg;

	localparam int IMG_WIDTH  = 800;
	localparam int IMG_HEIGHT = 480;
	localparam int BADGE_SIZE = 98;

	localparam int CELL_W   = 22;
	localparam int CELL_H   = 36;
	localparam int STROKE_W = 5;
	localparam int MID_LO   = CELL_H / 2 - STROKE_W / 2;
	localparam int MID_HI   = MID_LO + STROKE_W;

	localparam int OFF_W   = 18;
	localparam int BYTE_W  = 8;
	localparam int PAGE_W  = 3;
	localparam int PIX_W   = OFF_W + 1;
	localparam int S_DATA_W = ((OFF_W + BYTE_W + 7) / 8) * 8;

	localparam int X_W   = $clog2(IMG_WIDTH + 1);
	localparam int Y_W   = $clog2((2 ** PIX_W - 1) / IMG_WIDTH + 1);
	localparam int SUM_W = ((X_W > Y_W) ? X_W : Y_W) + 2;
	localparam int CX_W  = $clog2(CELL_W);
	localparam int CY_W  = $clog2(CELL_H);

	// exact division by the image width: q = (p * RECIP) >> DIV_SH for every p of PIX_W bits
	localparam int     DIV_SH  = PIX_W + $clog2(IMG_WIDTH);
	localparam int     RECIP_W = PIX_W + 2;
	localparam int     PROD_W  = PIX_W + RECIP_W;
	localparam longint RECIP   = ((longint'(1) << DIV_SH) + IMG_WIDTH - 1) / IMG_WIDTH;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	localparam int     ROWS0 = IMG_HEIGHT - BADGE_SIZE;
	localparam longint FIRST = (ROWS0 > 0) ? (longint'(ROWS0) * IMG_WIDTH) / 2 : 0;
	localparam logic [31:0] FIRST_C = 32'(FIRST);

	localparam logic signed [SUM_W-1:0] THRESH =
		SUM_W'(IMG_WIDTH - 1 + IMG_HEIGHT - 1 - BADGE_SIZE);
	localparam logic signed [SUM_W-1:0] CELL_X0 =
		SUM_W'(IMG_WIDTH - 1 - (BADGE_SIZE * 3) / 10 - CELL_W / 2);
	localparam logic signed [SUM_W-1:0] CELL_Y0 =
		SUM_W'(IMG_HEIGHT - 1 - (BADGE_SIZE * 3) / 10 - CELL_H / 2);
	localparam logic signed [SUM_W-1:0] CELL_W_S = SUM_W'(CELL_W);
	localparam logic signed [SUM_W-1:0] CELL_H_S = SUM_W'(CELL_H);

	localparam logic [3:0] PIX_BLACK = 4'h0;
	localparam logic [3:0] PIX_WHITE = 4'h1;

	localparam logic [PAGE_W-1:0] PAGE_RESET = PAGE_W'(1);
	localparam logic [PAGE_W-1:0] PAGE_ONE   = PAGE_W'(1);
	localparam logic [PAGE_W-1:0] PAGE_TWO   = PAGE_W'(2);
	localparam logic [PAGE_W-1:0] PAGE_THREE = PAGE_W'(3);
	localparam logic [PAGE_W-1:0] PAGE_FOUR  = PAGE_W'(4);

	typedef logic [6:0] seg_t;

	localparam seg_t SEG_TOP = 7'h01;
	localparam seg_t SEG_UR  = 7'h02;
	localparam seg_t SEG_LR  = 7'h04;
	localparam seg_t SEG_BOT = 7'h08;
	localparam seg_t SEG_LL  = 7'h10;
	localparam seg_t SEG_UL  = 7'h20;
	localparam seg_t SEG_MID = 7'h40;

	function automatic seg_t seg_for_page(logic [PAGE_W-1:0] page);
		seg_t s;
		unique case (page)
			PAGE_ONE:   s = SEG_UR | SEG_LR;
			PAGE_TWO:   s = SEG_TOP | SEG_UR | SEG_MID | SEG_LL | SEG_BOT;
			PAGE_THREE: s = SEG_TOP | SEG_UR | SEG_MID | SEG_LR | SEG_BOT;
			PAGE_FOUR:  s = SEG_UL | SEG_UR | SEG_MID | SEG_LR;
			default:    s = '0;
		endcase
		return s;
	endfunction

	function automatic logic stroke_lit(seg_t s, logic [CX_W-1:0] cx, logic [CY_W-1:0] cy);
		logic left, right, top, bot, mid, upper, lower;
		left  = cx < CX_W'(STROKE_W);
		right = cx >= CX_W'(CELL_W - STROKE_W);
		top   = cy < CY_W'(STROKE_W);
		bot   = cy >= CY_W'(CELL_H - STROKE_W);
		upper = cy < CY_W'(MID_HI);
		lower = cy >= CY_W'(MID_LO);
		mid   = upper && lower;
		return ((|(s & SEG_TOP)) && top) || ((|(s & SEG_BOT)) && bot) ||
			((|(s & SEG_MID)) && mid) ||
			((|(s & SEG_UL)) && left && upper) || ((|(s & SEG_LL)) && left && lower) ||
			((|(s & SEG_UR)) && right && upper) || ((|(s & SEG_LR)) && right && lower);
	endfunction

endpackage

/* rtl/corner_badge_pixel_overlay_core.sv */
// corner badge pixel overlay: four-rank pipeline from byte offset and pixel pair to overlaid pair
// throughput: one byte per cycle while m_tready is high; set by the register ranks around the reciprocal multiply
// stages: input rank, quotient rank, x/y rank, output register
// reset: pipeline empties, page_number returns to 1
module corner_badge_pixel_overlay_core
	import cbpo_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [PAGE_W-1:0]   cfg_wdata,   // page_number
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,     // byte_offset, data_in, zero padding
	input  logic                s_tlast,     // last_in
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [BYTE_W-1:0]   m_tdata,     // data_out
	output logic                m_tlast      // last_out
);

	logic [PAGE_W-1:0] page_number_q;

	logic v_s1, v_s2, v_s3, v_out_q;
	logic adv_s1, adv_s2, adv_s3, adv_out;

	logic [OFF_W-1:0]  off_s1;
	logic [BYTE_W-1:0] data_s1, data_s2, data_s3;
	logic              last_s1, last_s2, last_s3;

	logic [PIX_W-1:0]  p_s1, p_s2;
	logic              exam_s2, exam_s3;
	logic [PROD_W-1:0] prod;
	logic [Y_W-1:0]    q_s2, y_s3;
	logic [PIX_W-1:0]  rem;
	logic [X_W-1:0]    x_s3, x_right;

	logic [BYTE_W-1:0] data_out_q;
	logic              last_out_q;
	logic              page_ok;
	seg_t              segs;
	logic [3:0]        pix_left, pix_right;

	function automatic logic [3:0] overlay_pix(logic [3:0] pix, logic [X_W-1:0] x,
		logic [Y_W-1:0] y, logic en, seg_t s);
		logic signed [SUM_W-1:0] sum, cx, cy;
		logic in_cell;
		sum = $signed(SUM_W'(x)) + $signed(SUM_W'(y));
		cx  = $signed(SUM_W'(x)) - CELL_X0;
		cy  = $signed(SUM_W'(y)) - CELL_Y0;
		in_cell = !cx[SUM_W-1] && (cx < CELL_W_S) && !cy[SUM_W-1] && (cy < CELL_H_S);
		if (!en || sum < THRESH) begin
			return pix;
		end
		return (in_cell && stroke_lit(s, cx[CX_W-1:0], cy[CY_W-1:0])) ? PIX_WHITE : PIX_BLACK;
	endfunction

	// stall chain
	assign adv_out  = !v_out_q || m_tready;
	assign adv_s3   = !v_s3 || adv_out;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_number_q <= PAGE_RESET;
		end else if (cfg_we) begin
			page_number_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				v_out_q <= v_s3;
			end
		end
	end

	// input rank
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			off_s1  <= s_tdata[OFF_W-1:0];
			data_s1 <= s_tdata[OFF_W +: BYTE_W];
			last_s1 <= s_tlast;
		end
	end

	assign p_s1 = {off_s1, 1'b0};
	assign prod = PROD_W'(p_s1) * PROD_W'(RECIP_C);

	// quotient rank: y of the pixel pair
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			p_s2    <= p_s1;
			q_s2    <= prod[DIV_SH +: Y_W];
			exam_s2 <= 32'(off_s1) >= FIRST_C;
			data_s2 <= data_s1;
			last_s2 <= last_s1;
		end
	end

	assign rem = p_s2 - PIX_W'(PIX_W'(q_s2) * PIX_W'(IMG_WIDTH));

	// x/y rank
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			x_s3    <= rem[X_W-1:0];
			y_s3    <= q_s2;
			exam_s3 <= exam_s2;
			data_s3 <= data_s2;
			last_s3 <= last_s2;
		end
	end

	assign page_ok   = (page_number_q != '0) && (page_number_q <= PAGE_FOUR);
	assign segs      = seg_for_page(page_number_q);
	assign x_right   = x_s3 + X_W'(1);
	assign pix_left  = overlay_pix(data_s3[7:4], x_s3, y_s3, exam_s3 && page_ok, segs);
	assign pix_right = overlay_pix(data_s3[3:0], x_right, y_s3, exam_s3 && page_ok, segs);

	// output register
	always_ff @(posedge clk) begin
		if (adv_out) begin
			data_out_q <= {pix_left, pix_right};
			last_out_q <= last_s3;
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tdata  = data_out_q;
	assign m_tlast  = last_out_q;

endmodule

/* rtl/cbpo_checker.sv */
// port-level checker for the corner badge pixel overlay, bound to the top level
module cbpo_checker
	import cbpo_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [BYTE_W-1:0]   m_tdata,
	input logic                m_tlast
);

	logic [2:0] inflight_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// bytes taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (!in_xfer && out_xfer) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 3'd0)
		else $error("result offered with nothing in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more bytes in flight than pipeline ranks");

endmodule

bind corner_badge_pixel_overlay_core cbpo_checker u_cbpo_checker (.*);

/* dv/corner_badge_pixel_overlay_core_tb.sv */
// self-checking testbench for the corner badge pixel overlay core
module corner_badge_pixel_overlay_core_tb;
	import cbpo_pkg::*;

	localparam int TRI_SUM   = IMG_WIDTH - 1 + IMG_HEIGHT - 1 - BADGE_SIZE;
	localparam int BOX_X0    = IMG_WIDTH - 1 - (BADGE_SIZE * 3) / 10 - CELL_W / 2;
	localparam int BOX_Y0    = IMG_HEIGHT - 1 - (BADGE_SIZE * 3) / 10 - CELL_H / 2;
	localparam int FIRST_OFF = (IMG_HEIGHT > BADGE_SIZE) ?
		(IMG_HEIGHT - BADGE_SIZE) * IMG_WIDTH / 2 : 0;

	localparam int RDY_OPEN   = 0;
	localparam int RDY_CHOPPY = 1;
	localparam int RDY_SPARSE = 2;

	typedef struct packed {
		logic [OFF_W-1:0]  off;
		logic [BYTE_W-1:0] pix;
		logic              last;
	} pair_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] pix;
		logic              last;
	} pair_out_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [PAGE_W-1:0]   cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [BYTE_W-1:0]   m_tdata;
	logic                m_tlast;

	pair_in_t          byte_feed_q[$];
	pair_out_t         overlay_exp_q[$];
	pair_in_t          cur_byte;
	pair_out_t         exp_byte;
	pair_out_t         got_byte;
	logic [PAGE_W-1:0] page_sel = PAGE_RESET;
	int                burst_left, gap_left, rdy_mode, rdy_left;
	int                n_sent, n_seen, n_altered, n_fail, n_pages;

	corner_badge_pixel_overlay_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("tb: failure");
		$finish;
	end

	function automatic bit on_digit(logic [PAGE_W-1:0] pg, int cx, int cy);
		bit top, bot, mid, lft, rgt, upr, lwr;
		top = cy < STROKE_W;
		bot = cy >= CELL_H - STROKE_W;
		upr = cy < MID_HI;
		lwr = cy >= MID_LO;
		mid = upr && lwr;
		lft = cx < STROKE_W;
		rgt = cx >= CELL_W - STROKE_W;
		case (pg)
			PAGE_ONE:   return rgt && (upr || lwr);
			PAGE_TWO:   return top || bot || mid || (rgt && upr) || (lft && lwr);
			PAGE_THREE: return top || bot || mid || (rgt && upr) || (rgt && lwr);
			PAGE_FOUR:  return mid || (lft && upr) || (rgt && upr) || (rgt && lwr);
			default:    return 1'b0;
		endcase
	endfunction

	// -1 leaves the pixel as it is
	function automatic int badge_pixel(logic [PAGE_W-1:0] pg, int x, int y);
		int cx, cy;
		if (pg < PAGE_ONE || pg > PAGE_FOUR)
			return -1;
		if (x + y < TRI_SUM)
			return -1;
		cx = x - BOX_X0;
		cy = y - BOX_Y0;
		if (cx >= 0 && cx < CELL_W && cy >= 0 && cy < CELL_H && on_digit(pg, cx, cy))
			return int'(PIX_WHITE);
		return int'(PIX_BLACK);
	endfunction

	function automatic logic [BYTE_W-1:0] badge_overlay(logic [PAGE_W-1:0] pg,
			logic [OFF_W-1:0] off, logic [BYTE_W-1:0] pix);
		int p, x, y, v;
		logic [BYTE_W-1:0] r;
		r = pix;
		if (int'(off) >= FIRST_OFF) begin
			p = 2 * int'(off);
			y = p / IMG_WIDTH;
			x = p % IMG_WIDTH;
			v = badge_pixel(pg, x, y);
			if (v >= 0)
				r[7:4] = 4'(v);
			v = badge_pixel(pg, x + 1, y);
			if (v >= 0)
				r[3:0] = 4'(v);
		end
		return r;
	endfunction

	function automatic logic [OFF_W-1:0] pix_off(int x, int y);
		return OFF_W'((y * IMG_WIDTH + x) / 2);
	endfunction

	task automatic queue_byte(logic [OFF_W-1:0] off, logic [BYTE_W-1:0] pix, logic last);
		pair_in_t it;
		it.off  = off;
		it.pix  = pix;
		it.last = last;
		byte_feed_q.push_back(it);
	endtask

	// mostly the badge corner, some plain image and some offsets past the image
	task automatic queue_random_byte();
		int kind, x, y;
		logic [OFF_W-1:0] off;
		logic [BYTE_W-1:0] pix;
		kind = $urandom_range(0, 19);
		if (kind < 10) begin
			y = $urandom_range(BOX_Y0 - 4, IMG_HEIGHT - 1);
			x = $urandom_range(BOX_X0 - 6, IMG_WIDTH - 1) & ~1;
			off = pix_off(x, y);
		end else if (kind < 15) begin
			y = $urandom_range(IMG_HEIGHT - BADGE_SIZE, IMG_HEIGHT - 1);
			x = (TRI_SUM - y + int'($urandom_range(0, 20)) - 10) & ~1;
			if (x < 0)
				x = 0;
			if (x > IMG_WIDTH - 2)
				x = IMG_WIDTH - 2;
			off = pix_off(x, y);
		end else if (kind < 18) begin
			off = OFF_W'($urandom_range(0, IMG_WIDTH * IMG_HEIGHT / 2 - 1));
		end else if (kind == 18) begin
			off = OFF_W'($urandom_range(IMG_WIDTH * IMG_HEIGHT / 2, 2 ** OFF_W - 1));
		end else begin
			off = OFF_W'($urandom);
		end
		if ($urandom_range(0, 7) == 0)
			pix = $urandom_range(0, 1) ? 8'hff : 8'h00;
		else
			pix = BYTE_W'($urandom);
		queue_byte(off, pix, $urandom_range(0, 7) == 0);
	endtask

	// wait for every queued byte to go in and every result to come out
	task automatic drain();
		do
			@(posedge clk);
		while (byte_feed_q.size() != 0 || s_tvalid || overlay_exp_q.size() != 0);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_page(int v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= PAGE_W'(v);
		page_sel  = PAGE_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_pages++;
	endtask

	// driver: bursts of transfers separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tlast    <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				exp_byte.pix  = badge_overlay(page_sel, cur_byte.off, cur_byte.pix);
				exp_byte.last = cur_byte.last;
				overlay_exp_q.push_back(exp_byte);
				n_sent++;
				if (exp_byte.pix != cur_byte.pix)
					n_altered++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (byte_feed_q.size() > 0) begin
					cur_byte = byte_feed_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= S_DATA_W'({cur_byte.pix, cur_byte.off});
					s_tlast  <= cur_byte.last;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: switches between always ready, choppy and mostly stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rdy_mode = RDY_OPEN;
			rdy_left = 0;
		end else begin
			if (rdy_left == 0) begin
				rdy_mode = $urandom_range(RDY_OPEN, RDY_SPARSE);
				rdy_left = $urandom_range(8, 60);
			end else begin
				rdy_left--;
			end
			case (rdy_mode)
				RDY_OPEN:   m_tready <= 1'b1;
				RDY_CHOPPY: m_tready <= $urandom_range(0, 1);
				default:    m_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_seen++;
			if (overlay_exp_q.size() == 0) begin
				$error("unexpected transfer: data_out %h, last_out %b", m_tdata, m_tlast);
				n_fail++;
			end else begin
				got_byte = overlay_exp_q.pop_front();
				if (m_tdata !== got_byte.pix) begin
					$error("data_out mismatch: expected %h, actual %h", got_byte.pix, m_tdata);
					n_fail++;
				end
				if (m_tlast !== got_byte.last) begin
					$error("last_out mismatch: expected %b, actual %b", got_byte.last, m_tlast);
					n_fail++;
				end
			end
		end
	end

	initial begin
		int pages[$];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset page, edges of the examined area and of the digit cell, offsets past the image
		queue_byte('0, 8'h00, 1'b0);
		queue_byte('0, 8'hff, 1'b1);
		queue_byte(OFF_W'(FIRST_OFF - 1), 8'hff, 1'b0);
		queue_byte(OFF_W'(FIRST_OFF), 8'hff, 1'b0);
		queue_byte(pix_off(TRI_SUM - (IMG_HEIGHT - BADGE_SIZE) - 1,
			IMG_HEIGHT - BADGE_SIZE), 8'hff, 1'b0);
		queue_byte(pix_off(IMG_WIDTH - 2, IMG_HEIGHT - 1), 8'hff, 1'b1);
		queue_byte(OFF_W'(IMG_WIDTH * IMG_HEIGHT / 2), 8'h5a, 1'b0);
		queue_byte('1, 8'hff, 1'b1);
		queue_byte(OFF_W'(1 << (OFF_W - 1)), 8'ha5, 1'b0);
		queue_byte(pix_off(BOX_X0 - 1, BOX_Y0), 8'hff, 1'b0);
		queue_byte(pix_off(BOX_X0 + CELL_W - 2, BOX_Y0), 8'hff, 1'b0);
		queue_byte(pix_off(BOX_X0 + CELL_W, BOX_Y0), 8'h00, 1'b0);
		queue_byte(pix_off(BOX_X0 + 3, BOX_Y0 + MID_LO), 8'h00, 1'b0);
		queue_byte(pix_off(BOX_X0 + 5, BOX_Y0 + MID_LO), 8'h77, 1'b1);
		queue_byte(pix_off(BOX_X0 + 11, BOX_Y0 + MID_HI - 1), 8'hee, 1'b0);
		queue_byte(pix_off(BOX_X0 + 11, BOX_Y0 + MID_HI), 8'hee, 1'b0);
		queue_byte(pix_off(BOX_X0 + 15, BOX_Y0 + STROKE_W - 1), 8'h33, 1'b0);
		queue_byte(pix_off(BOX_X0 + 19, BOX_Y0 + CELL_H - 1), 8'hcc, 1'b0);
		queue_byte(pix_off(BOX_X0 + 19, BOX_Y0 + CELL_H), 8'hcc, 1'b1);
		queue_byte(pix_off(IMG_WIDTH / 2, IMG_HEIGHT / 2), 8'h81, 1'b0);
		for (int i = 0; i < 40; i++)
			queue_random_byte();
		drain();

		pages = '{2, 3, 4, 0, 7, 5, 6, 1};
		repeat (3)
			pages.push_back($urandom_range(0, 7));
		foreach (pages[i]) begin
			write_page(pages[i]);
			for (int j = 0; j < 50; j++)
				queue_random_byte();
			drain();
		end
		repeat (8) @(posedge clk);

		if (overlay_exp_q.size() != 0) begin
			$error("%0d results never arrived", overlay_exp_q.size());
			n_fail++;
		end
		$display("tb: %0d bytes in, %0d checked out, %0d changed by the badge",
			n_sent, n_seen, n_altered);
		$display("tb: %0d page settings written, digits one to four and disabled pages",
			n_pages);
		if (n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
